/* hdl/uae_pkg.sv */
// -----------------------------------------------------------------------------
// uae_pkg
// Shared types, constants and helpers of the URI action name extractor.
// -----------------------------------------------------------------------------
package uae_pkg;

	localparam int SLASH_HOLD_DEF = 16;
	localparam int HOLD_MAX       = 16;
	localparam int CMD_DEPTH_DEF  = 4;

	localparam int SCHEME_LEN = 12;
	localparam int HOST_LEN   = 14;
	localparam int KEY_LEN    = 4;

	// scheme prefix, host word and key word, lowercase
	localparam logic [7:0] SCHEME_WORD [SCHEME_LEN] = '{
		8'h77, 8'h69, 8'h6E, 8'h74, 8'h61, 8'h6E,
		8'h67, 8'h6C, 8'h65, 8'h3A, 8'h2F, 8'h2F
	};
	localparam logic [7:0] HOST_WORD [HOST_LEN] = '{
		8'h65, 8'h78, 8'h65, 8'h63, 8'h75, 8'h74, 8'h65,
		8'h2D, 8'h61, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E
	};
	localparam logic [7:0] KEY_WORD [KEY_LEN] = '{8'h6E, 8'h61, 8'h6D, 8'h65};

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_BAD_SCH  = 3'd1;
	localparam logic [2:0] ST_BAD_HOST = 3'd2;
	localparam logic [2:0] ST_NO_QUERY = 3'd3;
	localparam logic [2:0] ST_NO_NAME  = 3'd4;
	localparam logic [2:0] ST_SLASH_OV = 3'd5;

	// one command: emitted in field order, each part only when enabled
	typedef struct packed {
		logic       pre_pct;
		logic       pre_hex;
		logic [7:0] hex_byte;
		logic [4:0] nslash;
		logic       ch_en;
		logic [7:0] ch;
		logic       st_en;
		logic [2:0] st;
	} uae_cmd_t;

	typedef struct packed {
		logic     empty;
		uae_cmd_t cmd;
	} uae_q_head_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

endpackage

/* hdl/uae_if.sv */
// -----------------------------------------------------------------------------
// uae_in_if / uae_out_if
// Valid/ready channels for URI bytes in and extracted results out.
// -----------------------------------------------------------------------------
interface uae_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_uri;

	modport source (output valid, output char_in, output end_of_uri, input ready);
	modport sink (input valid, input char_in, input end_of_uri, output ready);
endinterface

interface uae_out_if;
	logic       valid;
	logic       ready;
	logic       is_status;
	logic [7:0] value_char;
	logic [2:0] status;
	logic       last;

	modport source (output valid, output is_status, output value_char, output status,
		output last, input ready);
	modport sink (input valid, input is_status, input value_char, input status,
		input last, output ready);
endinterface

/* hdl/uae_front.sv */
// -----------------------------------------------------------------------------
// uae_front
// Parses a URI byte per cycle, if the queue has room, into at most one command.
// -----------------------------------------------------------------------------
module uae_front
	import uae_pkg::*;
#(
	parameter int SLASH_HOLD = SLASH_HOLD_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	uae_in_if.sink   uri,
	input  logic     q_full,
	output logic     push,
	output uae_cmd_t cmd
);

	localparam int         HoldCap  = (SLASH_HOLD < HOLD_MAX) ? SLASH_HOLD : HOLD_MAX;
	localparam logic [4:0] HOLD_CAP = 5'(HoldCap);

	localparam logic [2:0] PH_SCHEME = 3'd0;
	localparam logic [2:0] PH_HOST   = 3'd1;
	localparam logic [2:0] PH_KEY    = 3'd2;
	localparam logic [2:0] PH_SKIP   = 3'd3;
	localparam logic [2:0] PH_VALUE  = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_ONE  = 2'd2;

	logic [2:0] phase_q, nxt_phase;
	logic [3:0] pos_q, nxt_pos;
	logic       key_ok_q, nxt_key_ok;
	logic [1:0] esc_q, nxt_esc;
	logic [7:0] fh_q, nxt_fh;
	logic [4:0] hs_q, nxt_hs;
	logic [2:0] code_q, nxt_code;

	logic       accept;
	logic [7:0] c, lc;
	logic [4:0] hx, hx_first;

	assign uri.ready = !q_full;
	assign accept    = uri.valid && uri.ready;
	assign c         = uri.char_in;
	assign lc        = to_lower(c);
	assign hx        = hex_nib(c);
	assign hx_first  = hex_nib(fh_q);

	always_comb begin
		logic [1:0] esc_e;
		logic       pass;
		nxt_phase  = phase_q;
		nxt_pos    = pos_q;
		nxt_key_ok = key_ok_q;
		nxt_esc    = esc_q;
		nxt_fh     = fh_q;
		nxt_hs     = hs_q;
		nxt_code   = code_q;
		cmd        = '0;
		esc_e      = esc_q;
		pass       = 1'b0;

		unique case (phase_q)
			PH_SCHEME: begin
				if (pos_q < 4'(SCHEME_LEN) && lc == SCHEME_WORD[pos_q]) begin
					nxt_pos = 4'(pos_q + 4'd1);
					if (pos_q == 4'(SCHEME_LEN - 1)) begin
						nxt_phase = PH_HOST;
						nxt_pos   = 4'd0;
					end
				end else begin
					nxt_phase = PH_DONE;
					nxt_code  = ST_BAD_SCH;
				end
			end
			PH_HOST: begin
				if (hs_q != 5'd0) begin
					if (c != CH_SLASH) begin
						nxt_phase = PH_DONE;
						nxt_code  = ST_BAD_HOST;
					end
				end else if (c == CH_QM) begin
					if (pos_q == 4'(HOST_LEN)) begin
						nxt_phase  = PH_KEY;
						nxt_pos    = 4'd0;
						nxt_key_ok = 1'b1;
					end else begin
						nxt_phase = PH_DONE;
						nxt_code  = ST_BAD_HOST;
					end
				end else if (c == CH_SLASH && pos_q == 4'(HOST_LEN)) begin
					nxt_hs = 5'd1;
				end else if (pos_q < 4'(HOST_LEN) && lc == HOST_WORD[pos_q]) begin
					nxt_pos = 4'(pos_q + 4'd1);
				end else begin
					nxt_phase = PH_DONE;
					nxt_code  = ST_BAD_HOST;
				end
			end
			PH_KEY: begin
				if (c == CH_AMP) begin
					nxt_pos    = 4'd0;
					nxt_key_ok = 1'b1;
				end else if (c == CH_EQ) begin
					if (key_ok_q && pos_q == 4'(KEY_LEN)) begin
						nxt_phase = PH_VALUE;
						nxt_esc   = ESC_IDLE;
						nxt_hs    = 5'd0;
					end else begin
						nxt_phase = PH_SKIP;
					end
				end else if (pos_q < 4'(KEY_LEN) && lc == KEY_WORD[pos_q[1:0]]) begin
					nxt_pos = 4'(pos_q + 4'd1);
				end else begin
					nxt_key_ok = 1'b0;
				end
			end
			PH_SKIP: begin
				if (c == CH_AMP) begin
					nxt_phase  = PH_KEY;
					nxt_pos    = 4'd0;
					nxt_key_ok = 1'b1;
				end
			end
			PH_VALUE: begin
				if (uri.end_of_uri && c == CH_SLASH) begin
					// final slash: drop held slashes, flush any pending escape
					cmd.pre_pct  = (esc_q != ESC_IDLE);
					cmd.pre_hex  = (esc_q == ESC_ONE);
					cmd.hex_byte = to_lower(fh_q);
					nxt_esc      = ESC_IDLE;
				end else if (c == CH_SLASH) begin
					if (hs_q >= HOLD_CAP) begin
						nxt_hs    = 5'd0;
						nxt_esc   = ESC_IDLE;
						nxt_phase = PH_DONE;
						nxt_code  = ST_SLASH_OV;
					end else begin
						nxt_hs = 5'(hs_q + 5'd1);
					end
				end else begin
					// release held slashes; the first one breaks a pending escape
					if (hs_q != 5'd0) begin
						cmd.pre_pct  = (esc_q != ESC_IDLE);
						cmd.pre_hex  = (esc_q == ESC_ONE);
						cmd.hex_byte = to_lower(fh_q);
						cmd.nslash   = hs_q;
						esc_e        = ESC_IDLE;
						nxt_hs       = 5'd0;
					end
					if (c == CH_AMP) begin
						if (esc_e != ESC_IDLE) cmd.pre_pct = 1'b1;
						if (esc_e == ESC_ONE) begin
							cmd.pre_hex  = 1'b1;
							cmd.hex_byte = to_lower(fh_q);
						end
						nxt_esc   = ESC_IDLE;
						nxt_phase = PH_DONE;
						nxt_code  = ST_FOUND;
					end else begin
						nxt_esc = ESC_IDLE;
						pass    = 1'b1;
						if (esc_e == ESC_PCT) begin
							if (hx[4]) begin
								nxt_esc = ESC_ONE;
								nxt_fh  = c;
								pass    = 1'b0;
							end else begin
								cmd.pre_pct = 1'b1;
							end
						end else if (esc_e == ESC_ONE) begin
							if (hx[4]) begin
								cmd.ch_en = 1'b1;
								cmd.ch    = to_lower({hx_first[3:0], hx[3:0]});
								pass      = 1'b0;
							end else begin
								cmd.pre_pct  = 1'b1;
								cmd.pre_hex  = 1'b1;
								cmd.hex_byte = to_lower(fh_q);
							end
						end
						if (pass) begin
							if (c == CH_PCT) begin
								nxt_esc = ESC_PCT;
							end else begin
								cmd.ch_en = 1'b1;
								cmd.ch    = (c == CH_PLUS) ? CH_SPACE : lc;
							end
						end
						// an escape still open at the end passes through raw
						if (uri.end_of_uri) begin
							if (nxt_esc == ESC_PCT) begin
								cmd.ch_en = 1'b1;
								cmd.ch    = CH_PCT;
							end else if (nxt_esc == ESC_ONE) begin
								cmd.pre_pct  = 1'b1;
								cmd.pre_hex  = 1'b1;
								cmd.hex_byte = lc;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (uri.end_of_uri) begin
			cmd.st_en = 1'b1;
			priority if (nxt_phase == PH_SCHEME) cmd.st = ST_BAD_SCH;
			else if (nxt_phase == PH_HOST)
				cmd.st = (nxt_pos == 4'(HOST_LEN)) ? ST_NO_QUERY : ST_BAD_HOST;
			else if (nxt_phase == PH_KEY || nxt_phase == PH_SKIP) cmd.st = ST_NO_NAME;
			else if (nxt_phase == PH_VALUE) cmd.st = ST_FOUND;
			else cmd.st = nxt_code;
			nxt_phase  = PH_SCHEME;
			nxt_pos    = 4'd0;
			nxt_key_ok = 1'b1;
			nxt_esc    = ESC_IDLE;
			nxt_fh     = 8'd0;
			nxt_hs     = 5'd0;
			nxt_code   = ST_FOUND;
		end
	end

	assign push = accept && (cmd.pre_pct || cmd.pre_hex || cmd.nslash != 5'd0 ||
		cmd.ch_en || cmd.st_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SCHEME;
			pos_q    <= 4'd0;
			key_ok_q <= 1'b1;
			esc_q    <= ESC_IDLE;
			fh_q     <= 8'd0;
			hs_q     <= 5'd0;
			code_q   <= ST_FOUND;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			pos_q    <= nxt_pos;
			key_ok_q <= nxt_key_ok;
			esc_q    <= nxt_esc;
			fh_q     <= nxt_fh;
			hs_q     <= nxt_hs;
			code_q   <= nxt_code;
		end
	end

endmodule

/* hdl/uae_cmd_fifo.sv */
// -----------------------------------------------------------------------------
// uae_cmd_fifo
// Short command queue between the parser and the result sequencer.
// -----------------------------------------------------------------------------
module uae_cmd_fifo
	import uae_pkg::*;
#(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  uae_cmd_t    cmd_in,
	input  logic        pop,
	output uae_q_head_t head,
	output logic        full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	uae_cmd_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	assign full       = (cnt_q == CW'(DEPTH));
	assign head.empty = (cnt_q == '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop) cnt_q <= CW'(cnt_q + 1'b1);
			else if (pop && !push) cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

endmodule

/* hdl/uae_back.sv */
// -----------------------------------------------------------------------------
// uae_back
// Expands queued commands into result beats, one per cycle unless stalled.
// -----------------------------------------------------------------------------
module uae_back
	import uae_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  uae_q_head_t  head,
	output logic         pop,
	uae_out_if.source    result
);

	localparam logic [2:0] EL_PCT   = 3'd0;
	localparam logic [2:0] EL_HEX   = 3'd1;
	localparam logic [2:0] EL_SLASH = 3'd2;
	localparam logic [2:0] EL_CH    = 3'd3;
	localparam logic [2:0] EL_ST    = 3'd4;

	logic       out_valid_q;
	logic       is_status_q;
	logic [7:0] value_char_q;
	logic [2:0] status_q;
	logic [2:0] ptr_q;
	logic [4:0] scnt_q;

	logic [4:0] pres;
	logic [2:0] cur;
	logic       more, stay, advance, take;
	logic       el_is_st;
	logic [7:0] el_char;

	assign pres = {head.cmd.st_en, head.cmd.ch_en, head.cmd.nslash != 5'd0,
		head.cmd.pre_hex, head.cmd.pre_pct};

	always_comb begin
		priority if (pres[EL_PCT] && ptr_q <= EL_PCT) cur = EL_PCT;
		else if (pres[EL_HEX] && ptr_q <= EL_HEX) cur = EL_HEX;
		else if (pres[EL_SLASH] && ptr_q <= EL_SLASH) cur = EL_SLASH;
		else if (pres[EL_CH] && ptr_q <= EL_CH) cur = EL_CH;
		else cur = EL_ST;

		el_is_st = 1'b0;
		unique case (cur)
			EL_PCT:   el_char = CH_PCT;
			EL_HEX:   el_char = head.cmd.hex_byte;
			EL_SLASH: el_char = CH_SLASH;
			EL_CH:    el_char = head.cmd.ch;
			default: begin
				el_char  = 8'd0;
				el_is_st = 1'b1;
			end
		endcase
	end

	assign more    = |(pres & (5'b11110 << cur));
	assign stay    = (cur == EL_SLASH) && (5'(scnt_q + 5'd1) < head.cmd.nslash);
	assign advance = !out_valid_q || result.ready;
	assign take    = advance && !head.empty;
	assign pop     = take && !stay && !more;

	assign result.valid      = out_valid_q;
	assign result.is_status  = is_status_q;
	assign result.value_char = value_char_q;
	assign result.status     = status_q;
	assign result.last       = is_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ptr_q       <= EL_PCT;
			scnt_q      <= 5'd0;
		end else begin
			if (advance) out_valid_q <= !head.empty;
			if (take) begin
				if (pop) begin
					ptr_q  <= EL_PCT;
					scnt_q <= 5'd0;
				end else if (stay) begin
					scnt_q <= 5'(scnt_q + 5'd1);
				end else begin
					ptr_q  <= 3'(cur + 3'd1);
					scnt_q <= 5'd0;
				end
			end
		end
	end

	// hold the beat while the sink stalls
	always_ff @(posedge clk) begin
		if (take) begin
			is_status_q  <= el_is_st;
			value_char_q <= el_char;
			status_q     <= el_is_st ? head.cmd.st : ST_FOUND;
		end
	end

endmodule

/* hdl/uri_action_name_extractor.sv */
// -----------------------------------------------------------------------------
// uri_action_name_extractor
// Extracts and decodes the "name" query value of a URI byte stream.
// -----------------------------------------------------------------------------
// One URI byte is taken per cycle while the queue is not full. The parser turns
// each byte into at most one command for a queue of CMD_DEPTH entries. The
// sequencer behind it sends one result beat per cycle while the sink is ready.
// Beats pass through the queue and then the output register. Most bytes give
// no beat or one. A byte that breaks an escape gives up to three, plus the
// status if it ends the URI. A byte that releases held slashes gives up to 20:
// the escape remnant, up to 16 slashes, the byte and the status. Such a command
// holds the queue head until its beats are out, so the queue can fill even with
// the result side always ready. Input stalls whenever the queue is full, even
// for bytes that give no beat. Every URI ends with a status beat with last set.
module uri_action_name_extractor
	import uae_pkg::*;
#(
	parameter int SLASH_HOLD = SLASH_HOLD_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	uae_in_if.sink    uri,
	uae_out_if.source result
);

	logic        push, pop, q_full;
	uae_cmd_t    cmd;
	uae_q_head_t head;

	uae_front #(.SLASH_HOLD(SLASH_HOLD)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.uri    (uri),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd)
	);

	uae_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	uae_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

	a_value_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.is_status) |-> (result.status == ST_FOUND && !result.last))
		else $error("value beat carries status bits");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.is_status) |-> (result.value_char == 8'd0 && result.last))
		else $error("status beat carries value bits");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!head.empty && (!result.valid || result.ready)) |=> result.valid)
		else $error("queued command not turned into a beat");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !head.empty)
		else $error("queue popped while empty");

endmodule

/* tb/sv/uri_action_name_extractor_tb.sv */
// -----------------------------------------------------------------------------
// uri_action_name_extractor_tb
// Self-checking bench: URI bytes in, decoded name value and status beats out.
// -----------------------------------------------------------------------------
// A table of directed URIs runs first. Rows with an obvious outcome carry their
// expected beats; all other rows, and the random URIs after them, are checked
// against a byte-level parser model kept in this bench. Both channel sides
// idle and stall at random, and the receiver once holds off long enough to
// back the block up into its input.
module uri_action_name_extractor_tb;
	import uae_pkg::*;

	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_CAP        = (SLASH_HOLD_DEF < HOLD_MAX) ? SLASH_HOLD_DEF : HOLD_MAX;
	localparam int PREFIX_LEN      = SCHEME_LEN + HOST_LEN;
	localparam int RANDOM_BYTES    = 220;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int DRAIN_CYCLES    = 40;

	typedef enum logic [2:0] {PH_SCHEME, PH_HOST, PH_KEY, PH_SKIP, PH_VALUE, PH_DONE} parse_ph_e;
	typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_ONE} esc_e;
	typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} case_mode_e;

	typedef struct packed {
		logic       is_status;
		logic [7:0] value_char;
		logic [2:0] status;
		logic       last;
	} beat_t;

	typedef struct {
		int         pre;
		case_mode_e pre_case;
		string      text;
		bit         tail_en;
		logic [7:0] tail;
		bit         typed;
		string      value;
		logic [2:0] status;
	} dir_row_t;

	logic clk;
	logic arst_n;

	uae_in_if  uri_ch();
	uae_out_if res_ch();

	uri_action_name_extractor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.uri(uri_ch),
		.result(res_ch)
	);

	// parser model state
	parse_ph_e  parse_ph;
	int         word_idx;
	bit         key_match;
	esc_e       esc_st;
	logic [7:0] esc_digit;
	int         slash_cnt;
	logic [2:0] decided_code;

	beat_t    expected_beats[$];
	dir_row_t dir_rows[$];

	int errors;
	int cycle_cnt;
	bit hold_off_req;
	int src_idle_pct;
	int snk_stall_pct;
	int src_idle_by_mode[4] = '{0, 66, 0, 14};
	int snk_stall_by_mode[4] = '{0, 0, 66, 14};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic logic [7:0] lower_of(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
	endfunction

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66)
			return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46)
			return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void emit_value(input logic [7:0] c);
		beat_t b;
		b.is_status = 1'b0;
		b.value_char = lower_of(c);
		b.status = '0;
		b.last = 1'b0;
		expected_beats.push_back(b);
	endfunction

	function automatic void emit_status(input logic [2:0] st);
		beat_t b;
		b.is_status = 1'b1;
		b.value_char = '0;
		b.status = st;
		b.last = 1'b1;
		expected_beats.push_back(b);
	endfunction

	function automatic void reset_parser();
		parse_ph = PH_SCHEME;
		word_idx = 0;
		key_match = 1'b1;
		esc_st = ESC_IDLE;
		esc_digit = '0;
		slash_cnt = 0;
		decided_code = '0;
	endfunction

	function automatic void decide(input logic [2:0] code);
		decided_code = code;
		parse_ph = PH_DONE;
	endfunction

	function automatic void open_pair();
		parse_ph = PH_KEY;
		word_idx = 0;
		key_match = 1'b1;
	endfunction

	function automatic void flush_escape();
		if (esc_st == ESC_PCT) begin
			emit_value(CH_PCT);
		end else if (esc_st == ESC_ONE) begin
			emit_value(CH_PCT);
			emit_value(esc_digit);
		end
		esc_st = ESC_IDLE;
	endfunction

	function automatic void decode_value_byte(input logic [7:0] c);
		int h;
		int hi;
		h = nibble_of(c);
		if (esc_st == ESC_PCT) begin
			if (h >= 0) begin
				esc_digit = c;
				esc_st = ESC_ONE;
				return;
			end
			emit_value(CH_PCT);
			esc_st = ESC_IDLE;
		end else if (esc_st == ESC_ONE) begin
			if (h >= 0) begin
				hi = nibble_of(esc_digit);
				if (hi < 0)
					hi = 0;
				emit_value(8'(hi * 16 + h));
				esc_st = ESC_IDLE;
				return;
			end
			// broken escape: pass it through raw
			emit_value(CH_PCT);
			emit_value(esc_digit);
			esc_st = ESC_IDLE;
		end
		if (c == CH_PCT)
			esc_st = ESC_PCT;
		else if (c == CH_PLUS)
			emit_value(CH_SPACE);
		else
			emit_value(c);
	endfunction

	function automatic void value_step(input logic [7:0] c);
		if (c == CH_SLASH) begin
			if (slash_cnt >= HOLD_CAP) begin
				slash_cnt = 0;
				esc_st = ESC_IDLE;
				decide(ST_SLASH_OV);
			end else begin
				slash_cnt++;
			end
			return;
		end
		// release held slashes ahead of a non-slash byte
		while (slash_cnt > 0) begin
			decode_value_byte(CH_SLASH);
			slash_cnt--;
		end
		if (c == CH_AMP) begin
			flush_escape();
			decide(ST_FOUND);
			return;
		end
		decode_value_byte(c);
	endfunction

	function automatic void predict_byte(input logic [7:0] c, input logic eou);
		logic [7:0] lc;
		logic [2:0] code;
		lc = lower_of(c);
		case (parse_ph)
			PH_SCHEME: begin
				if (word_idx < SCHEME_LEN && lc == SCHEME_WORD[word_idx]) begin
					word_idx++;
					if (word_idx == SCHEME_LEN) begin
						parse_ph = PH_HOST;
						word_idx = 0;
					end
				end else begin
					decide(ST_BAD_SCH);
				end
			end
			PH_HOST: begin
				if (slash_cnt != 0) begin
					if (c != CH_SLASH)
						decide(ST_BAD_HOST);
				end else if (c == CH_QM) begin
					if (word_idx == HOST_LEN)
						open_pair();
					else
						decide(ST_BAD_HOST);
				end else if (c == CH_SLASH && word_idx == HOST_LEN) begin
					slash_cnt = 1;
				end else if (word_idx < HOST_LEN && lc == HOST_WORD[word_idx]) begin
					word_idx++;
				end else begin
					decide(ST_BAD_HOST);
				end
			end
			PH_KEY: begin
				if (c == CH_AMP) begin
					open_pair();
				end else if (c == CH_EQ) begin
					if (key_match && word_idx == KEY_LEN) begin
						parse_ph = PH_VALUE;
						esc_st = ESC_IDLE;
						slash_cnt = 0;
					end else begin
						parse_ph = PH_SKIP;
					end
				end else if (word_idx < KEY_LEN && lc == KEY_WORD[word_idx]) begin
					word_idx++;
				end else begin
					key_match = 1'b0;
				end
			end
			PH_SKIP: begin
				if (c == CH_AMP)
					open_pair();
			end
			PH_VALUE: begin
				// a slash on the final byte is simply dropped
				if (!(eou && c == CH_SLASH))
					value_step(c);
			end
			default: ;
		endcase
		if (!eou)
			return;
		case (parse_ph)
			PH_SCHEME: code = ST_BAD_SCH;
			PH_HOST: code = (word_idx == HOST_LEN) ? ST_NO_QUERY : ST_BAD_HOST;
			PH_KEY, PH_SKIP: code = ST_NO_NAME;
			PH_VALUE: begin
				flush_escape();
				code = ST_FOUND;
			end
			default: code = decided_code;
		endcase
		emit_status(code);
		reset_parser();
	endfunction

	// ------------------------------------------------------------- stimulus

	function automatic logic [7:0] case_mix(input logic [7:0] c, input case_mode_e mode);
		if (c >= 8'h61 && c <= 8'h7A &&
				(mode == CASE_UPPER || (mode == CASE_MIXED && $urandom_range(0, 1) == 1)))
			return 8'(c - 8'd32);
		return c;
	endfunction

	function automatic void put_prefix(ref logic [7:0] q[$], input int n, input case_mode_e mode);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = (i < SCHEME_LEN) ? SCHEME_WORD[i] : HOST_WORD[i - SCHEME_LEN];
			q.push_back(case_mix(c, mode));
		end
	endfunction

	function automatic void put_text(ref logic [7:0] q[$], input string s, input case_mode_e mode);
		foreach (s[i])
			q.push_back(case_mix(s[i], mode));
	endfunction

	function automatic logic [7:0] any_hex();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 8'(8'h30 + v);
		if (v < 16)
			return 8'(8'h61 + v - 10);
		return 8'(8'h41 + v - 16);
	endfunction

	function automatic string slash_run(input int n);
		string s;
		s = "";
		repeat (n) s = {s, "/"};
		return s;
	endfunction

	function automatic void add_row(input int pre, input case_mode_e pre_case, input string text,
			input bit tail_en, input logic [7:0] tail, input bit typed, input string value,
			input logic [2:0] status);
		dir_row_t r;
		r.pre = pre;
		r.pre_case = pre_case;
		r.text = text;
		r.tail_en = tail_en;
		r.tail = tail;
		r.typed = typed;
		r.value = value;
		r.status = status;
		dir_rows.push_back(r);
	endfunction

	function automatic void put_value(ref logic [7:0] q[$]);
		int n;
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 11))
				0, 1: q.push_back(8'($urandom_range(8'h41, 8'h5A)));
				2: q.push_back(8'($urandom_range(8'h61, 8'h7A)));
				3: q.push_back(8'($urandom_range(8'h30, 8'h39)));
				4: begin
					q.push_back(CH_PCT);
					repeat ($urandom_range(0, 2)) q.push_back(any_hex());
				end
				5: q.push_back(CH_PLUS);
				6: begin
					n = ($urandom_range(0, 7) == 0) ?
						$urandom_range(HOLD_CAP - 2, HOLD_CAP + 1) : $urandom_range(1, 3);
					repeat (n) q.push_back(CH_SLASH);
				end
				7: q.push_back(CH_EQ);
				8: q.push_back(CH_AMP);
				9: q.push_back(8'($urandom_range(0, 255)));
				default: q.push_back(any_hex());
			endcase
		end
	endfunction

	// mostly well-formed URIs with random content; some noise and broken ones
	function automatic void make_random_uri(ref logic [7:0] q[$]);
		int kind;
		int n;
		q.delete();
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		put_prefix(q, PREFIX_LEN, CASE_MIXED);
		if (kind == 1)
			q[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom_range(0, 255));
		if (kind == 2) begin
			repeat ($urandom_range(1, 3)) q.push_back(CH_SLASH);
			if ($urandom_range(0, 1) == 1)
				q.push_back(CH_QM);
		end else if (kind != 3) begin
			q.push_back(CH_QM);
			n = $urandom_range(1, 3);
			for (int p = 0; p < n; p++) begin
				if (p != 0)
					q.push_back(CH_AMP);
				case ($urandom_range(0, 7))
					0: put_text(q, "nam", CASE_MIXED);
					1: put_text(q, "names", CASE_MIXED);
					2: put_text(q, "id", CASE_MIXED);
					3: ;
					default: put_text(q, "name", CASE_MIXED);
				endcase
				if ($urandom_range(0, 9) != 0) begin
					q.push_back(CH_EQ);
					put_value(q);
				end
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) q.push_back(CH_SLASH);
		end
		if (kind == 3) begin
			// cut short inside the prefix or right after it
			n = $urandom_range(1, q.size());
			while (q.size() > n)
				void'(q.pop_back());
		end
	endfunction

	function automatic void set_idling(input int mode);
		src_idle_pct = src_idle_by_mode[mode];
		snk_stall_pct = snk_stall_by_mode[mode];
	endfunction

	// entered just after a falling edge; returns just after one once accepted
	task automatic send_byte(input logic [7:0] c, input logic eou, input bit use_model);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			uri_ch.valid <= 1'b0;
			@(negedge clk);
		end
		uri_ch.valid <= 1'b1;
		uri_ch.char_in <= c;
		uri_ch.end_of_uri <= eou;
		if (use_model)
			predict_byte(c, eou);
		@(posedge clk);
		while (!uri_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_uri(input logic [7:0] q[$], input bit use_model);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1, use_model);
	endtask

	task automatic wait_drained();
		uri_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_beats.size() != 0);
	endtask

	// ------------------------------------------------------------ processes

	initial begin
		dir_row_t   row;
		logic [7:0] uri_bytes[$];
		int         uri_no;
		int         rand_bytes;

		arst_n = 1'b0;
		uri_ch.valid = 1'b0;
		uri_ch.char_in = '0;
		uri_ch.end_of_uri = 1'b0;
		errors = 0;
		hold_off_req = 1'b0;
		uri_no = 0;
		set_idling(0);
		reset_parser();

		add_row(0, CASE_LOWER, "", 1, 8'h00, 1, "", ST_BAD_SCH);
		add_row(0, CASE_LOWER, "", 1, 8'hFF, 1, "", ST_BAD_SCH);
		add_row(SCHEME_LEN - 1, CASE_UPPER, "x", 0, 8'h00, 1, "", ST_BAD_SCH);
		add_row(SCHEME_LEN + 7, CASE_LOWER, "", 0, 8'h00, 1, "", ST_BAD_HOST);
		add_row(PREFIX_LEN, CASE_LOWER, "", 0, 8'h00, 1, "", ST_NO_QUERY);
		add_row(PREFIX_LEN, CASE_LOWER, "///", 0, 8'h00, 1, "", ST_NO_QUERY);
		add_row(PREFIX_LEN, CASE_LOWER, "/x?name=a", 0, 8'h00, 1, "", ST_BAD_HOST);
		add_row(PREFIX_LEN, CASE_LOWER, "?", 0, 8'h00, 1, "", ST_NO_NAME);
		add_row(PREFIX_LEN, CASE_LOWER, "?names=a&nam=b&xname=c", 0, 8'h00, 1, "", ST_NO_NAME);
		add_row(PREFIX_LEN, CASE_UPPER, "?NAME=Ab+c", 0, 8'h00, 1, "ab c", ST_FOUND);
		add_row(PREFIX_LEN, CASE_MIXED, "?a=1&name=x%41%4a%zz%4", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=%", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=%4", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=%4F", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=a/b//c///", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=%2///", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, {"?name=", slash_run(HOLD_CAP), "x"},
			0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, {"?name=", slash_run(HOLD_CAP + 1), "x"},
			0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, {"?name=%4", slash_run(HOLD_CAP), "z"},
			0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=ab&name=cd", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_MIXED, "?NaMe=a=b+%3d", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?x&name=%g1%A", 0, 8'h00, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=", 1, 8'hFF, 0, "", ST_FOUND);
		add_row(PREFIX_LEN, CASE_LOWER, "?name=", 1, 8'h00, 0, "", ST_FOUND);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			set_idling(uri_no % 4);
			uri_bytes.delete();
			put_prefix(uri_bytes, row.pre, row.pre_case);
			put_text(uri_bytes, row.text, CASE_LOWER);
			if (row.tail_en)
				uri_bytes.push_back(row.tail);
			if (row.typed) begin
				foreach (row.value[i])
					emit_value(row.value[i]);
				emit_status(row.status);
			end
			send_uri(uri_bytes, !row.typed);
			uri_no++;
		end

		// hold input until everything so far has come out
		wait_drained();

		// long receiver hold-off against a slash-heavy URI, sender running flat out
		set_idling(0);
		uri_bytes.delete();
		put_prefix(uri_bytes, PREFIX_LEN, CASE_MIXED);
		put_text(uri_bytes, {"?name=", slash_run(HOLD_CAP), "b", slash_run(HOLD_CAP), "%41&z"},
			CASE_LOWER);
		hold_off_req = 1'b1;
		send_uri(uri_bytes, 1'b1);
		rand_bytes = uri_bytes.size();

		while (rand_bytes < RANDOM_BYTES) begin
			set_idling(uri_no % 4);
			make_random_uri(uri_bytes);
			send_uri(uri_bytes, 1'b1);
			rand_bytes += uri_bytes.size();
			uri_no++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0)
			$display("** uri_action_name_extractor: PASSED **");
		else
			$display("** uri_action_name_extractor: FAILED **");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.is_status = res_ch.is_status;
			got.value_char = res_ch.value_char;
			got.status = res_ch.status;
			got.last = res_ch.last;
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: beat with nothing expected: is_status=%0b value=%h status=%0d last=%0b",
					$time, got.is_status, got.value_char, got.status, got.last);
			end else begin
				want = expected_beats.pop_front();
				if (got.is_status !== want.is_status || got.value_char !== want.value_char ||
						got.status !== want.status || got.last !== want.last) begin
					errors++;
					$display("%0t: mismatch expected is_status=%0b value=%h status=%0d last=%0b",
						$time, want.is_status, want.value_char, want.status, want.last);
					$display("%0t:          actual   is_status=%0b value=%h status=%0d last=%0b",
						$time, got.is_status, got.value_char, got.status, got.last);
				end
			end
		end
	end

	initial cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
			$display("** uri_action_name_extractor: FAILED **");
			$finish;
		end
	end

endmodule
